// ----- rtl/cusum_recovery_selector_defines.svh -----
// Assertion helpers for the recovery selector RTL.
`ifndef CUSUM_RECOVERY_SELECTOR_DEFINES_SVH
`define CUSUM_RECOVERY_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CRS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("crs check failed");

// Next-cycle implication, disabled while reset is high.
`define CRS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("crs check failed");

`endif

// ----- rtl/crs_pkg.sv -----
`default_nettype none

package crs_pkg;

   localparam int AXES    = 3;
   localparam int ANGLE_W = 31;
   localparam int CFG_W   = 31;
   localparam int SUM_W   = 32;
   localparam int IDX_W   = 3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_BIAS_ROLL   = 3'd0;
   localparam logic [IDX_W-1:0] REG_BIAS_PITCH  = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIAS_YAW    = 3'd2;
   localparam logic [IDX_W-1:0] REG_LIMIT_ROLL  = 3'd3;
   localparam logic [IDX_W-1:0] REG_LIMIT_PITCH = 3'd4;
   localparam logic [IDX_W-1:0] REG_LIMIT_YAW   = 3'd5;
   localparam logic [IDX_W-1:0] REG_EXIT_TOL    = 3'd6;

   // reset values
   localparam logic [CFG_W-1:0] BIAS_RESET  = '0;
   localparam logic [CFG_W-1:0] LIMIT_RESET = '1;
   localparam logic [CFG_W-1:0] TOL_RESET   = 31'd6554;  // 0.1 in Q15.16

   typedef logic signed [ANGLE_W-1:0] angle_q16_type;

   typedef struct packed {
      logic [AXES-1:0][CFG_W-1:0] bias;
      logic [AXES-1:0][CFG_W-1:0] limit;
      logic [CFG_W-1:0]           tol;
   } crs_cfg_type;

   typedef struct packed {
      logic over;    // updated sum above limit
      logic close;   // |residual - bias| below tolerance
   } crs_axis_status_type;

endpackage

`default_nettype wire

// ----- rtl/crs_req_if.sv -----
`default_nettype none

interface crs_req_if import crs_pkg::*; ();
   logic          valid;
   logic          ready;
   angle_q16_type model_roll;
   angle_q16_type model_pitch;
   angle_q16_type model_yaw;
   angle_q16_type ctrl_roll;
   angle_q16_type ctrl_pitch;
   angle_q16_type ctrl_yaw;

   modport source (output valid, model_roll, model_pitch, model_yaw,
                   ctrl_roll, ctrl_pitch, ctrl_yaw, input ready);
   modport sink   (input valid, model_roll, model_pitch, model_yaw,
                   ctrl_roll, ctrl_pitch, ctrl_yaw, output ready);
endinterface

`default_nettype wire

// ----- rtl/crs_rsp_if.sv -----
`default_nettype none

interface crs_rsp_if import crs_pkg::*; ();
   logic          valid;
   logic          ready;
   angle_q16_type chosen_roll;
   angle_q16_type chosen_pitch;
   angle_q16_type chosen_yaw;
   logic          in_recovery;

   modport source (output valid, chosen_roll, chosen_pitch, chosen_yaw,
                   in_recovery, input ready);
   modport sink   (input valid, chosen_roll, chosen_pitch, chosen_yaw,
                   in_recovery, output ready);
endinterface

`default_nettype wire

// ----- rtl/crs_csr.sv -----
`default_nettype none

module crs_csr import crs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_data,
   output crs_cfg_type           cfg
);

   crs_cfg_type cfg_ff;
   crs_cfg_type cfg_in;

   // register decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BIAS_ROLL:   cfg_in.bias[0]  = csr_data;
            REG_BIAS_PITCH:  cfg_in.bias[1]  = csr_data;
            REG_BIAS_YAW:    cfg_in.bias[2]  = csr_data;
            REG_LIMIT_ROLL:  cfg_in.limit[0] = csr_data;
            REG_LIMIT_PITCH: cfg_in.limit[1] = csr_data;
            REG_LIMIT_YAW:   cfg_in.limit[2] = csr_data;
            REG_EXIT_TOL:    cfg_in.tol      = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bias  <= {AXES{BIAS_RESET}};
         cfg_ff.limit <= {AXES{LIMIT_RESET}};
         cfg_ff.tol   <= TOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/crs_axis.sv -----
`default_nettype none

module crs_axis import crs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             update,
   input  wire angle_q16_type    model,
   input  wire angle_q16_type    ctrl,
   input  wire logic [CFG_W-1:0] bias,
   input  wire logic [CFG_W-1:0] limit,
   input  wire logic [CFG_W-1:0] tol,
   output crs_axis_status_type   status
);

   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [ANGLE_W:0]   diff;
   logic [ANGLE_W:0]   diff_mag;
   logic [ANGLE_W-1:0] resid;
   logic [SUM_W+1:0]   acc;
   logic [CFG_W:0]     dev;
   logic [CFG_W:0]     dev_mag;

   // residual |model - ctrl|, always fits in 31 bits
   always_comb begin
      diff     = {model[ANGLE_W-1], model} - {ctrl[ANGLE_W-1], ctrl};
      diff_mag = diff[ANGLE_W] ? ((ANGLE_W+1)'(0) - diff) : diff;
      resid    = diff_mag[ANGLE_W-1:0];
   end

   // one-sided sum: clamp at zero below, saturate above
   always_comb begin
      acc = {2'b00, sum_ff} + {3'b000, resid} - {3'b000, bias};
      if (acc[SUM_W+1]) begin
         sum_in = '0;
      end else if (acc[SUM_W]) begin
         sum_in = '1;
      end else begin
         sum_in = acc[SUM_W-1:0];
      end
   end

   // exit test on |residual - bias|
   always_comb begin
      dev           = {1'b0, resid} - {1'b0, bias};
      dev_mag       = dev[CFG_W] ? ((CFG_W+1)'(0) - dev) : dev;
      status.over   = sum_in > {1'b0, limit};
      status.close  = dev_mag < {1'b0, tol};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (update) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cusum_recovery_selector.sv -----
// Channel   Port        Dir  Contents
// request   req_chan    in   model and controller roll/pitch/yaw, Q15.16
// result    rsp_chan    out  chosen roll/pitch/yaw, in_recovery
// config    csr_*       in   write enable, index 0..6, 31-bit data
//
// One request per cycle sustained while the result side is ready.
// The request register feeds the per-axis sum update and the result register.
// Sums and the recovery flag advance only when a request moves into the result.
// A stalled result holds; the request register takes one more, then input stalls.
// Synchronous active-high reset clears sums, flag and valids; config goes to defaults.
`default_nettype none
`include "cusum_recovery_selector_defines.svh"

module cusum_recovery_selector import crs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   crs_req_if.sink               req_chan,
   crs_rsp_if.source             rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_data
);

   crs_cfg_type         cfg;
   crs_axis_status_type status [AXES];

   logic          s1_valid_ff;
   angle_q16_type model_ff [AXES];
   angle_q16_type ctrl_ff  [AXES];

   logic          rsp_valid_ff;
   logic          rsp_flag_ff;
   angle_q16_type chosen_ff [AXES];

   logic      flag_ff;
   logic      flag_in;
   logic      rsp_free;
   logic      advance;
   logic      req_take;
   logic      any_over;
   logic      all_close;

   crs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // handshake: result slot free, request stage moves forward
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         model_ff[0] <= req_chan.model_roll;
         model_ff[1] <= req_chan.model_pitch;
         model_ff[2] <= req_chan.model_yaw;
         ctrl_ff[0]  <= req_chan.ctrl_roll;
         ctrl_ff[1]  <= req_chan.ctrl_pitch;
         ctrl_ff[2]  <= req_chan.ctrl_yaw;
      end
   end

   // per-axis sums
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      crs_axis u_axis (
         .clock  (clock),
         .reset  (reset),
         .update (advance),
         .model  (model_ff[a]),
         .ctrl   (ctrl_ff[a]),
         .bias   (cfg.bias[a]),
         .limit  (cfg.limit[a]),
         .tol    (cfg.tol),
         .status (status[a])
      );
   end

   // recovery flag: set on any sum over limit, clear when all axes settle
   always_comb begin
      any_over  = 1'b0;
      all_close = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         any_over  = any_over | status[a].over;
         all_close = all_close & status[a].close;
      end
      flag_in = (flag_ff || any_over) && !all_close;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            flag_ff <= flag_in;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flag_ff <= flag_in;
         for (int a = 0; a < AXES; a++) begin
            chosen_ff[a] <= flag_in ? model_ff[a] : ctrl_ff[a];
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.in_recovery  = rsp_flag_ff;
   assign rsp_chan.chosen_roll  = chosen_ff[0];
   assign rsp_chan.chosen_pitch = chosen_ff[1];
   assign rsp_chan.chosen_yaw   = chosen_ff[2];

   // checks
   `CRS_ASSERT_NOW(a_flag_matches, clock, reset, rsp_valid_ff, rsp_flag_ff == flag_ff)
   `CRS_ASSERT_NEXT(a_req_held, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   `CRS_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid_ff)
   `CRS_ASSERT_NOW(a_ready_when_empty, clock, reset, !s1_valid_ff, req_chan.ready)

endmodule

`default_nettype wire
